[rtl/core/dip_rrip_dead_block_replacement_top_macros.svh]
// assertion macros shared by the checker of the replacement policy block
// no dependencies
`ifndef DIP_RRIP_DEAD_BLOCK_REPLACEMENT_TOP_MACROS_SVH
`define DIP_RRIP_DEAD_BLOCK_REPLACEMENT_TOP_MACROS_SVH

// property checked only while reset is low
`define DRB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define DRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/drb_pkg.sv]
// shared types, constants and parameter defaults of the replacement policy block
// no dependencies
package drb_pkg;

   localparam int DEF_SETS        = 2048;
   localparam int DEF_WAYS        = 16;
   localparam int DEF_MAX_LEADERS = 64;

   localparam logic       MODE_VICTIM  = 1'b0;
   localparam logic       MODE_UPDATE  = 1'b1;
   localparam logic [1:0] RRPV_MAX     = 2'd3;
   localparam logic [1:0] DEAD_MAX     = 2'd3;
   localparam logic [1:0] DEAD_FAR     = 2'd2;
   localparam logic [9:0] SEL_MID      = 10'd512;
   localparam logic [9:0] SEL_MAX      = 10'd1023;
   localparam logic [6:0] LEADER_RESET = 7'd64;
   localparam int         RED_SHIFT    = 22;

   // controller to datapath
   typedef struct packed {
      logic clear_we;
      logic load;
      logic read;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } sts_type;

endpackage

[rtl/core/drb_ctrl.sv]
// sequencer of the replacement policy block: clearing pass, accept, read, commit
// depends on drb_pkg
module drb_ctrl
   import drb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_MOD   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

[rtl/core/drb_datapath.sv]
// datapath: set reduction, per-set counter row memory, victim and update logic,
// policy selector, leader register and result register; depends on drb_pkg
module drb_datapath
   import drb_pkg::*;
#(
   parameter int SETS        = DEF_SETS,
   parameter int WAYS        = DEF_WAYS,
   parameter int MAX_LEADERS = DEF_MAX_LEADERS
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        in_mode,
   input  logic [10:0] in_set_index,
   input  logic [3:0]  in_way_index,
   input  logic        in_is_hit,
   input  logic [15:0] in_valid_mask,
   input  logic [4:0]  in_bip_draw,
   input  logic        csr_valid,
   input  logic [6:0]  csr_data,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [3:0]  out_victim_way,
   output logic [1:0]  out_inserted_value,
   output logic [9:0]  out_selector_value
);

   localparam int SET_W = $clog2(SETS);
   localparam int WAY_W = $clog2(WAYS);
   localparam int ROW_W = 4 * WAYS;
   localparam int RECIP = ((1 << RED_SHIFT) + SETS - 1) / SETS;

   // captured item
   logic        mode_ff;
   logic [10:0] idx_ff;
   logic [3:0]  way_ff;
   logic        hit_ff;
   logic [15:0] mask_ff;
   logic [4:0]  draw_ff;
   logic [10:0] q_ff;
   logic [SET_W-1:0] set_ff;

   logic [31:0] recip_prod, q_mul, rem;

   // quotient by reciprocal, exact for 11-bit set indexes
   assign recip_prod = {21'b0, in_set_index} * 32'(RECIP);
   assign q_mul      = {21'b0, q_ff} * 32'(SETS);
   assign rem        = {21'b0, idx_ff} - q_mul;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= in_mode;
         idx_ff  <= in_set_index;
         way_ff  <= in_way_index;
         hit_ff  <= in_is_hit;
         mask_ff <= in_valid_mask;
         draw_ff <= in_bip_draw;
         q_ff    <= 11'(recip_prod >> RED_SHIFT);
      end
      if (cmd.read) set_ff <= SET_W'(rem);
   end

   // row memory: re-reference values low, dead counters high
   logic [ROW_W-1:0] mem [SETS];
   logic [ROW_W-1:0] row_ff, new_row, wdata;
   logic [SET_W-1:0] clr_cnt_ff, waddr;
   logic             we;

   assign we    = cmd.clear_we | cmd.commit;
   assign waddr = cmd.clear_we ? clr_cnt_ff : set_ff;
   assign wdata = cmd.clear_we ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.read) row_ff <= mem[SET_W'(rem)];
   end

   always_ff @(posedge clock) begin
      if (reset)             clr_cnt_ff <= '0;
      else if (cmd.clear_we) clr_cnt_ff <= clr_cnt_ff + 1'b1;
   end

   assign sts.clear_last = (clr_cnt_ff == SET_W'(SETS - 1));
   assign sts.out_free   = ~rsp_tvalid | rsp_tready;

   // policy selector and leader count
   logic [9:0] sel_ff, sel_in;
   logic [6:0] lead_ff;

   always_ff @(posedge clock) begin
      if (reset)          lead_ff <= LEADER_RESET;
      else if (csr_valid) lead_ff <= csr_data;
   end

   // modify step
   logic [1:0]       rr   [WAYS];
   logic [1:0]       dc   [WAYS];
   logic [1:0]       rr_n [WAYS];
   logic [1:0]       dc_n [WAYS];
   logic [WAYS-1:0]  valid_vec, hi_vec, lo_vec, lo_of_hi;
   logic             inv_found, way_ok, lip, bip, bimodal;
   logic [WAY_W-1:0] inv_way, age_way, vic_way, wsel;
   logic [1:0]       top, add, ins, dc_sel;
   logic [31:0]      eff, set_w, vic_wide;
   logic [9:0]       sel_up;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         rr[w]        = row_ff[2*w +: 2];
         dc[w]        = row_ff[2*WAYS + 2*w +: 2];
         valid_vec[w] = (w < 16) ? mask_ff[4'(w)] : 1'b1;
         hi_vec[w]    = rr[w][1];
         lo_vec[w]    = rr[w][0];
         lo_of_hi[w]  = rr[w][1] & rr[w][0];
      end

      // largest value in the set
      if (|hi_vec) top = {1'b1, |lo_of_hi};
      else         top = {1'b0, |lo_vec};
      add = RRPV_MAX - top;

      // first invalid way, and first way holding the largest value
      inv_found = 1'b0;
      inv_way   = '0;
      age_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!valid_vec[w]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
         if (rr[w] == top) age_way = WAY_W'(w);
      end

      // leader sets
      set_w = 32'(set_ff);
      eff   = (32'(lead_ff) > 32'(MAX_LEADERS)) ? 32'(MAX_LEADERS) : 32'(lead_ff);
      lip   = set_w < eff;
      bip   = (set_w >= 32'(SETS / 2)) && ((set_w - 32'(SETS / 2)) < eff);

      way_ok = 32'(way_ff) < 32'(WAYS);
      wsel   = WAY_W'(way_ff);
      dc_sel = dc[wsel];

      if (dc_sel >= DEAD_FAR) bimodal = 1'b0;
      else if (lip)           bimodal = 1'b0;
      else if (bip)           bimodal = 1'b1;
      else                    bimodal = sel_ff < SEL_MID;

      ins = (bimodal && draw_ff == 5'd0) ? 2'd0 : RRPV_MAX;

      // selector moves on a hit, each saturating
      sel_up = (lip && sel_ff < SEL_MAX) ? sel_ff + 10'd1 : sel_ff;
      sel_in = sel_ff;
      if (mode_ff == MODE_UPDATE && way_ok && hit_ff)
         sel_in = (bip && sel_up != 10'd0) ? sel_up - 10'd1 : sel_up;

      for (int w = 0; w < WAYS; w++) begin
         rr_n[w] = rr[w];
         dc_n[w] = dc[w];
         if (mode_ff == MODE_VICTIM && !inv_found) rr_n[w] = rr[w] + add;
         if (mode_ff == MODE_UPDATE && way_ok && wsel == WAY_W'(w)) begin
            if (hit_ff) begin
               rr_n[w] = 2'd0;
               dc_n[w] = 2'd0;
            end else begin
               rr_n[w] = ins;
               dc_n[w] = (dc[w] < DEAD_MAX) ? dc[w] + 2'd1 : dc[w];
            end
         end
         new_row[2*w +: 2]          = rr_n[w];
         new_row[2*WAYS + 2*w +: 2] = dc_n[w];
      end

      vic_way  = inv_found ? inv_way : age_way;
      vic_wide = (mode_ff == MODE_VICTIM) ? 32'(vic_way) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset)           sel_ff <= SEL_MID;
      else if (cmd.commit) sel_ff <= sel_in;
   end

   // result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.commit) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_victim_way     <= vic_wide[3:0];
         out_inserted_value <= (mode_ff == MODE_UPDATE && way_ok && !hit_ff) ? ins : 2'd0;
         out_selector_value <= sel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/core/dip_rrip_dead_block_replacement_top.sv]
// top level of the dynamic insertion replacement policy with dead counters
// depends on drb_pkg, drb_ctrl, drb_datapath
//
//  channel | direction | transaction
//  --------+-----------+---------------------------------------------------
//  req     | in        | one cache access: victim request or hit/fill update
//  rsp     | out       | victim way, inserted value, selector after the step
//  csr     | in        | write of the leader count register
//
// an access runs from accept to result through these steps: accept with reciprocal
// multiply, set reduction with the row memory read, modify and write back
// the separate read step comes from the single registered read port of the row memory
// after reset a clearing pass writes one row per cycle over all SETS rows
// (2048 by default) and no access is accepted meanwhile
// a result not taken holds the block in its modify step, the next access
// is accepted as soon as the result sits in the output register
module dip_rrip_dead_block_replacement_top
   import drb_pkg::*;
#(
   parameter int SETS        = DEF_SETS,
   parameter int WAYS        = DEF_WAYS,
   parameter int MAX_LEADERS = DEF_MAX_LEADERS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // set_index[10:0] way_index[14:11] is_hit[15]
                                   // valid_mask[31:16] bip_draw[36:32] zero[39:37]
   input  logic        req_tuser,  // mode[0]: victim request or update
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // victim_way[3:0] inserted_value[5:4]
                                   // selector_value[15:6]
   // leader count register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   cmd_type cmd;
   sts_type sts;

   logic [3:0] victim_way;
   logic [1:0] inserted_value;
   logic [9:0] selector_value;

   // register writes are always taken
   assign csr_ready = 1'b1;

   drb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   drb_datapath #(
      .SETS        (SETS),
      .WAYS        (WAYS),
      .MAX_LEADERS (MAX_LEADERS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .in_mode            (req_tuser),
      .in_set_index       (req_tdata[10:0]),
      .in_way_index       (req_tdata[14:11]),
      .in_is_hit          (req_tdata[15]),
      .in_valid_mask      (req_tdata[31:16]),
      .in_bip_draw        (req_tdata[36:32]),
      .csr_valid          (csr_valid),
      .csr_data           (csr_data),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .out_victim_way     (victim_way),
      .out_inserted_value (inserted_value),
      .out_selector_value (selector_value)
   );

   // pack the result fields, first field lowest
   assign rsp_tdata = {selector_value, inserted_value, victim_way};

endmodule

[rtl/core/drb_checker.sv]
// port-level checker of the replacement policy block and its bind
// depends on dip_rrip_dead_block_replacement_top_macros.svh
`include "dip_rrip_dead_block_replacement_top_macros.svh"

module drb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result holds its value
   `DRB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // one access at a time: no accept in the cycle after an accept
   `DRB_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "request accepted while busy")

   // a fill inserts either near or distant, never in between
   `DRB_ASSERT(a_ins_value, clock, reset, rsp_tvalid |-> (rsp_tdata[5:4] == 2'd0 || rsp_tdata[5:4] == 2'd3), "inserted value out of set")

   // reset empties the output and stops intake while clearing
   `DRB_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid && !req_tready, "activity right after reset")

endmodule

bind dip_rrip_dead_block_replacement_top drb_checker u_drb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
